[rtl/dlrd_pkg.sv]
package dlrd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEN_W   = 34;
    localparam int unsigned COUNT_W = 4;

    localparam logic [BYTE_W-1:0] MARK_FIRST  = 8'h1b;
    localparam logic [BYTE_W-1:0] MARK_SECOND = 8'h80;
    localparam logic [BYTE_W-1:0] DIGIT_LOW   = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HIGH  = 8'h39;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRUNCATED = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_MARK2  = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_DATA   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_result;

endpackage

[rtl/decimal_length_record_deframer_core.sv]
// record deframer for a byte stream
// slave side: one raw byte per word in s_axis_tdata, s_axis_tlast marks end of stream
// (the byte of such a word is ignored and the parser returns to its hunt state)
// master side: one result word per payload byte, or one marker word for an empty
// record or a record cut short by end of stream; kind in m_axis_tuser, record end
// in m_axis_tlast
// a record is 0x1b 0x80, LENGTH_DIGITS length characters whose leading decimal
// digits give the payload length, then the payload
// a word is held in the input register until the parser steps on it; its result is
// loaded into the output register at that step and is then shown on the master side
// throughput: one word per cycle while the receiver does not stall, set by the single parser step per word
// when the receiver stalls, the output register holds its word; the parser keeps
// taking words that give no result and stops only when a result finds the output
// register still full, then the input register fills and s_axis_tready drops
// reset (synchronous, active low) empties both registers and returns the parser
// to the hunt for the first mark byte
module decimal_length_record_deframer_core
    import dlrd_pkg::*;
#(
    parameter int unsigned LENGTH_DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,  // [7:0] payload_byte
    output logic [KIND_W-1:0] m_axis_tuser,  // [1:0] result_kind
    output logic              m_axis_tlast
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eos;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [KIND_W-1:0] r_out_kind;
    logic              r_out_last;

    t_result           result;
    logic              step;
    logic              out_free;
    logic              in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!result.valid || out_free);
    assign s_axis_tready = !r_in_valid || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    dlrd_parse #(
        .LENGTH_DIGITS(LENGTH_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_eos       (r_in_eos),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_eos  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && result.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out_byte <= result.data;
            r_out_kind <= result.kind;
            r_out_last <= result.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/dlrd_parse.sv]
module dlrd_parse
    import dlrd_pkg::*;
#(
    parameter int unsigned LENGTH_DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_eos,
    output t_result           o_result
);

    t_phase             r_phase,   n_phase;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic               r_stopped, n_stopped;
    logic [LEN_W-1:0]   r_length,  n_length;
    logic [LEN_W-1:0]   r_left,    n_left;

    logic               is_digit;
    logic [COUNT_W-1:0] count_inc;
    logic [LEN_W-1:0]   length_acc;
    logic [LEN_W-1:0]   left_dec;

    assign is_digit   = (i_data_byte >= DIGIT_LOW) && (i_data_byte <= DIGIT_HIGH);
    assign count_inc  = r_count + COUNT_W'(1);
    // times ten as two shifts and an add
    assign length_acc = (r_length << 3) + (r_length << 1)
                        + LEN_W'(i_data_byte - DIGIT_LOW);
    assign left_dec   = r_left - LEN_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_stopped = r_stopped;
        n_length  = r_length;
        n_left    = r_left;
        o_result  = '{valid: 1'b0, data: '0, kind: KIND_PAYLOAD, last: 1'b0};
        if (i_eos) begin
            n_phase   = PH_HUNT;
            n_count   = '0;
            n_stopped = 1'b0;
            n_length  = '0;
            n_left    = '0;
            if (r_phase == PH_LENGTH || r_phase == PH_DATA) begin
                o_result = '{valid: 1'b1, data: '0, kind: KIND_TRUNCATED, last: 1'b1};
            end
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_data_byte == MARK_FIRST) begin
                        n_phase = PH_MARK2;
                    end
                end
                PH_MARK2: begin
                    if (i_data_byte == MARK_SECOND) begin
                        n_phase   = PH_LENGTH;
                        n_count   = '0;
                        n_stopped = 1'b0;
                        n_length  = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    if (!r_stopped && is_digit) begin
                        n_length = length_acc;
                    end else begin
                        n_stopped = 1'b1;
                    end
                    n_count = count_inc;
                    if (count_inc >= COUNT_W'(LENGTH_DIGITS)) begin
                        n_count   = '0;
                        n_stopped = 1'b0;
                        if (n_length == '0) begin
                            n_phase  = PH_HUNT;
                            o_result = '{valid: 1'b1, data: '0, kind: KIND_EMPTY,
                                         last: 1'b1};
                        end else begin
                            n_left   = n_length;
                            n_length = '0;
                            n_phase  = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    n_left   = left_dec;
                    o_result = '{valid: 1'b1, data: i_data_byte, kind: KIND_PAYLOAD,
                                 last: (left_dec == '0)};
                    if (left_dec == '0) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_length  <= '0;
            r_left    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            r_length  <= n_length;
            r_left    <= n_left;
        end
    end

endmodule

[tb/sv/decimal_length_record_deframer_core_tb.sv]
module decimal_length_record_deframer_core_tb;
    import dlrd_pkg::*;

    localparam int NUM_CHARS    = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_WORDS = 1200;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;  // [7:0] data_byte
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;  // [7:0] payload_byte
    logic [KIND_W-1:0] m_axis_tuser;  // [1:0] result_kind
    logic              m_axis_tlast;

    bit steady;
    bit long_hold;
    int sent_words;

    class record_predictor;
        t_phase             phase;
        logic [COUNT_W-1:0] n_chars;
        logic               stopped;
        logic [LEN_W-1:0]   len_acc;
        logic [LEN_W-1:0]   left;
        t_result            expected_words[$];
        int                 errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase   = PH_HUNT;
            n_chars = '0;
            stopped = 1'b0;
            len_acc = '0;
            left    = '0;
        endfunction

        function void push(input logic [BYTE_W-1:0] d, input logic [KIND_W-1:0] k,
                           input logic l);
            t_result e;
            e.valid = 1'b1;
            e.data  = d;
            e.kind  = k;
            e.last  = l;
            expected_words = {expected_words, e};
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_word(input logic [BYTE_W-1:0] b, input logic eos);
            if (eos) begin
                if (phase == PH_LENGTH || phase == PH_DATA) begin
                    push('0, KIND_TRUNCATED, 1'b1);
                end
                clear();
                return;
            end
            case (phase)
                PH_HUNT: begin
                    if (b == MARK_FIRST) phase = PH_MARK2;
                end
                PH_MARK2: begin
                    if (b == MARK_SECOND) begin
                        phase   = PH_LENGTH;
                        n_chars = '0;
                        stopped = 1'b0;
                        len_acc = '0;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_LENGTH: begin
                    if (!stopped && b >= DIGIT_LOW && b <= DIGIT_HIGH) begin
                        len_acc = len_acc * LEN_W'(10) + LEN_W'(b - DIGIT_LOW);
                    end else begin
                        stopped = 1'b1;
                    end
                    n_chars = n_chars + 1'b1;
                    if (n_chars >= NUM_CHARS) begin
                        n_chars = '0;
                        stopped = 1'b0;
                        if (len_acc == 0) begin
                            phase = PH_HUNT;
                            push('0, KIND_EMPTY, 1'b1);
                        end else begin
                            left    = len_acc;
                            len_acc = '0;
                            phase   = PH_DATA;
                        end
                    end
                end
                default: begin
                    left = left - 1'b1;
                    if (left == 0) begin
                        phase = PH_HUNT;
                        push(b, KIND_PAYLOAD, 1'b1);
                    end else begin
                        push(b, KIND_PAYLOAD, 1'b0);
                    end
                end
            endcase
        endfunction

        function void check_word(input logic [BYTE_W-1:0] d, input logic [KIND_W-1:0] k,
                                 input logic l);
            t_result e;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got data %h kind %0d last %b",
                         $time, d, k, l);
                errors++;
                return;
            end
            e = expected_words[0];
            expected_words.delete(0);
            if (e.data !== d) begin
                $display("%0t: payload_byte expected %h got %h", $time, e.data, d);
                errors++;
            end
            if (e.kind !== k) begin
                $display("%0t: result_kind expected %0d got %0d", $time, e.kind, k);
                errors++;
            end
            if (e.last !== l) begin
                $display("%0t: last_of_record expected %b got %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    record_predictor deframer;

    decimal_length_record_deframer_core #(
        .LENGTH_DIGITS(NUM_CHARS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            deframer.note_word(s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            deframer.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_nondigit();
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? DIGIT_LOW - 1'b1 : DIGIT_HIGH + 1'b1;
        end
        c = BYTE_W'($urandom);
        while (c >= DIGIT_LOW && c <= DIGIT_HIGH) c = BYTE_W'($urandom);
        return c;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_words++;
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // length field either zero padded or cut short by a non-digit followed by junk
    task automatic send_record();
        logic [BYTE_W-1:0] digits[NUM_CHARS];
        logic [BYTE_W-1:0] chars[NUM_CHARS];
        logic [63:0]       n;
        logic [63:0]       v;
        int                first;
        int                lead;
        int                p;
        int                cut;
        int                body;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) n = {$urandom, $urandom} % 64'd10000000000;
        else if (pick < 15) n = 64'($urandom_range(100, 300));
        else n = 64'($urandom_range(0, 16));
        v     = n;
        first = NUM_CHARS;
        for (int i = NUM_CHARS - 1; i >= 0; i--) begin
            digits[i] = DIGIT_LOW + BYTE_W'(v % 10);
            v = v / 10;
            if (digits[i] != DIGIT_LOW) first = i;
        end
        lead = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 1 && lead + NUM_CHARS - first < NUM_CHARS) begin
            p = 0;
            for (int i = 0; i < lead; i++) begin
                chars[p] = DIGIT_LOW;
                p++;
            end
            for (int i = first; i < NUM_CHARS; i++) begin
                chars[p] = digits[i];
                p++;
            end
            chars[p] = pick_nondigit();
            p++;
            while (p < NUM_CHARS) begin
                chars[p] = BYTE_W'($urandom);
                p++;
            end
        end else begin
            chars = digits;
        end
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_SECOND, 1'b0);
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, NUM_CHARS - 1) : NUM_CHARS;
        for (int i = 0; i < cut; i++) send_byte(chars[i], 1'b0);
        if (cut < NUM_CHARS) begin
            send_byte(BYTE_W'($urandom), 1'b1);
            return;
        end
        if (n > 300) body = $urandom_range(1, 4);
        else if (n > 0 && $urandom_range(0, 19) == 0) body = $urandom_range(0, int'(n) - 1);
        else body = int'(n);
        for (int i = 0; i < body; i++) send_byte(BYTE_W'($urandom), 1'b0);
        if (body < n) send_byte(BYTE_W'($urandom), 1'b1);
    endtask

    task automatic send_noise();
        int                count;
        int                r;
        logic [BYTE_W-1:0] b;
        count = $urandom_range(0, 6);
        repeat (count) begin
            r = $urandom_range(0, 3);
            b = BYTE_W'($urandom);
            if (r == 0) b = MARK_FIRST;
            else if (r == 1) b = MARK_SECOND;
            send_byte(b, 1'b0);
        end
        send_byte(BYTE_W'($urandom), 1'b1);
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (steady || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    initial begin
        #8000000;
        $display("decimal_length_record_deframer_core regression: fail");
        $finish;
    end

    initial begin
        bit hold_done;
        bit drain_done;
        deframer      = new();
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        steady        = 1'b0;
        long_hold     = 1'b0;
        sent_words    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wrong second mark byte, then end of stream right after the first mark
        send_byte(8'hff, 1'b0);
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_SECOND, 1'b0);
        send_byte(MARK_FIRST, 1'b0);
        send_byte(8'h00, 1'b1);
        // non-digit ends the length
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_SECOND, 1'b0);
        send_chars("1/99999999");
        send_byte(8'hff, 1'b0);
        // largest length, cut by end of stream
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_SECOND, 1'b0);
        send_chars("9999999999");
        send_byte(8'h00, 1'b0);
        send_byte(8'h5a, 1'b1);
        // empty record from a non-digit first character
        send_byte(MARK_FIRST, 1'b0);
        send_byte(MARK_SECOND, 1'b0);
        send_chars(":000000000");
        send_byte(8'h00, 1'b1);

        while (sent_words < TARGET_WORDS) begin
            if (!hold_done && sent_words > 400) begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && sent_words > 800) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (deframer.pending() != 0);
                drain_done = 1'b1;
            end
            steady = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0) send_noise();
            else send_record();
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (deframer.pending() != 0);
        repeat (20) @(posedge i_clk);
        if (deframer.errors == 0 && deframer.pending() == 0) begin
            $display("decimal_length_record_deframer_core regression: pass");
        end else begin
            $display("decimal_length_record_deframer_core regression: fail");
        end
        $finish;
    end

endmodule
